/* rtl/vsrst_pkg.sv */
// ============================================================================
// vsrst_pkg: shared types, constants and functions
// Holds the fixed-point formats, the outline table and the CORDIC constants
// that the rotate-scale-translate block uses.
// ============================================================================
package vsrst_pkg;

    localparam int HULL_SEGMENTS  = 12;
    localparam int FLAME_SEGMENTS = 2;
    localparam int TRIG_FRAC_BITS = 15;

    localparam int HULL_CAP   = 32;
    localparam int FLAME_CAP  = 8;
    localparam int HULL_USED  = (HULL_SEGMENTS > HULL_CAP) ? HULL_CAP : HULL_SEGMENTS;
    localparam int FLAME_USED = (FLAME_SEGMENTS > FLAME_CAP) ? FLAME_CAP : FLAME_SEGMENTS;
    localparam int SEG_TOTAL  = HULL_USED + FLAME_USED;
    localparam int SEG_W      = $clog2(SEG_TOTAL + 1);

    // CORDIC datapath: 30 fractional bits, angles in 2^-32 turn.
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_FRAC  = 30;
    localparam int CW           = 34;
    localparam int ZW           = 34;
    localparam int SHW          = 5;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Trig values: Q1.TRIG_FRAC_BITS.
    localparam int TW       = TRIG_FRAC_BITS + 1;
    localparam int TRIG_SH  = CORDIC_FRAC - TRIG_FRAC_BITS;
    // Rotated point and scaled point widths.
    localparam int RW       = TW + 5;
    localparam int PW       = RW + 17;
    localparam int PLACE_SH = TRIG_FRAC_BITS + 8;

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    typedef struct packed {
        logic                    flip;
        logic [15:0]             zoom;
        logic signed [15:0]      ox;
        logic signed [15:0]      oy;
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ZW-1:0]    z;
    } cordic_t;

    typedef struct packed {
        logic signed [3:0] ax;
        logic signed [3:0] ay;
        logic signed [3:0] bx;
        logic signed [3:0] by;
    } seg_pts_t;

    // Negate a CORDIC result if neg, round it to Q1.TRIG_FRAC_BITS, saturate.
    function automatic logic signed [TW-1:0] to_trig(logic signed [CW-1:0] v, logic neg);
        logic signed [CW+1:0] w;
        logic signed [CW+1:0] r;
        w = neg ? -(CW+2)'(v) : (CW+2)'(v);
        r = (w + (CW+2)'(1 <<< (TRIG_SH - 1))) >>> TRIG_SH;
        if (r > (CW+2)'((1 <<< TRIG_FRAC_BITS) - 1))
            return TW'((1 <<< TRIG_FRAC_BITS) - 1);
        else if (r < -(CW+2)'(1 <<< TRIG_FRAC_BITS))
            return TW'(-(1 <<< TRIG_FRAC_BITS));
        else
            return r[TW-1:0];
    endfunction

    function automatic seg_pts_t hull_seg(logic [4:0] i);
        seg_pts_t p;
        case (i)
            5'd0:    p = '{-4'sd4,  4'sd3,  4'sd2,  4'sd0};
            5'd1:    p = '{-4'sd4, -4'sd3,  4'sd2,  4'sd0};
            5'd2:    p = '{-4'sd4, -4'sd3, -4'sd1,  4'sd4};
            5'd3:    p = '{-4'sd4,  4'sd3, -4'sd1, -4'sd4};
            5'd4:    p = '{-4'sd1,  4'sd4,  4'sd2,  4'sd0};
            5'd5:    p = '{-4'sd1, -4'sd4,  4'sd2,  4'sd0};
            5'd6:    p = '{ 4'sd2,  4'sd0,  4'sd3,  4'sd1};
            5'd7:    p = '{ 4'sd3,  4'sd1,  4'sd4,  4'sd0};
            5'd8:    p = '{ 4'sd2,  4'sd0,  4'sd3, -4'sd1};
            5'd9:    p = '{ 4'sd3, -4'sd1,  4'sd4,  4'sd0};
            5'd10:   p = '{-4'sd1,  4'sd4,  4'sd1,  4'sd4};
            5'd11:   p = '{-4'sd1, -4'sd4,  4'sd1, -4'sd4};
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic seg_pts_t flame_seg(logic [2:0] i);
        seg_pts_t p;
        case (i)
            3'd0:    p = '{-4'sd6, 4'sd0, -4'sd3,  4'sd2};
            3'd1:    p = '{-4'sd6, 4'sd0, -4'sd3, -4'sd2};
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic seg_pts_t seg_lookup(logic [SEG_W-1:0] k);
        logic [SEG_W+5:0] kk;
        logic [SEG_W+5:0] fk;
        kk = (SEG_W+6)'(k);
        fk = kk - (SEG_W+6)'(HULL_USED);
        if (kk < (SEG_W+6)'(HULL_USED))
            return hull_seg(kk[4:0]);
        else
            return flame_seg(fk[2:0]);
    endfunction

endpackage

/* rtl/vsrst_req_if.sv */
// ============================================================================
// vsrst_req_if: transform request channel
// Valid/ready channel carrying angle, zoom and screen origin.
// ============================================================================
interface vsrst_req_if;
    logic               valid;
    logic               ready;
    logic [15:0]        angle;
    logic [15:0]        zoom;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;

    modport source (output valid, angle, zoom, origin_x, origin_y, input ready);
    modport sink   (input valid, angle, zoom, origin_x, origin_y, output ready);
endinterface

/* rtl/vsrst_seg_if.sv */
// ============================================================================
// vsrst_seg_if: transformed segment channel
// Valid/ready channel carrying one transformed segment per item.
// ============================================================================
interface vsrst_seg_if;
    logic               valid;
    logic               ready;
    logic [3:0]         segment_index;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               last_segment;

    modport source (output valid, segment_index, start_x, start_y, end_x, end_y,
                    last_segment, input ready);
    modport sink   (input valid, segment_index, start_x, start_y, end_x, end_y,
                    last_segment, output ready);
endinterface

/* rtl/vsrst_cordic_cell.sv */
// ============================================================================
// vsrst_cordic_cell: one CORDIC rotation step
// Performs one micro-rotation and hands the result to the next cell.
// ============================================================================
module vsrst_cordic_cell
    import vsrst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [SHW-1:0]       shift,
    input  logic signed [ZW-1:0] atan,
    input  logic                 in_valid,
    input  cordic_t              in_data,
    output logic                 out_valid,
    output cordic_t              out_data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        dx = in_data.y >>> shift;
        dy = in_data.x >>> shift;
        data_next = in_data;
        if (!in_data.z[ZW-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - atan;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/vsrst_seg_unit.sv */
// ============================================================================
// vsrst_seg_unit: segment emitter
// Walks the outline table per job, transforming a segment per unstalled cycle.
// ============================================================================
module vsrst_seg_unit
    import vsrst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_take,
    input  logic signed [TW-1:0] job_cos,
    input  logic signed [TW-1:0] job_sin,
    input  logic [15:0]          job_zoom,
    input  logic signed [15:0]   job_ox,
    input  logic signed [15:0]   job_oy,
    vsrst_seg_if.source          seg
);

    localparam logic [SEG_W-1:0] LAST_K = SEG_W'(SEG_TOTAL - 1);

    logic                 en;
    logic                 busy_reg;
    logic [SEG_W-1:0]     k_reg;
    logic signed [TW-1:0] c_reg, s_reg;
    logic [15:0]          zoom_reg;
    logic signed [15:0]   ox_reg, oy_reg;

    // Stage A: rotated points.
    logic                 a_valid_reg;
    logic [SEG_W-1:0]     a_k_reg;
    logic signed [RW-1:0] a_rot_reg [4];
    logic [15:0]          a_zoom_reg;
    logic signed [15:0]   a_ox_reg, a_oy_reg;
    // Stage B: scaled points.
    logic                 b_valid_reg;
    logic [SEG_W-1:0]     b_k_reg;
    logic signed [PW-1:0] b_prod_reg [4];
    logic signed [15:0]   b_ox_reg, b_oy_reg;
    // Stage C: output register.
    logic                 c_valid_reg;
    logic [SEG_W-1:0]     c_k_reg;
    logic signed [15:0]   c_pt_reg [4];

    seg_pts_t             pts;
    logic signed [RW-1:0] rot_next [4];
    logic signed [15:0]   pt_next [4];
    logic signed [PW-1:0] rounded [4];
    logic signed [PW:0]   placed [4];

    assign en       = !c_valid_reg || seg.ready;
    assign job_take = en && job_valid && (!busy_reg || k_reg == LAST_K);

    always_comb
    begin
        pts = seg_lookup(k_reg);
        rot_next[0] = RW'(pts.ax * c_reg) - RW'(pts.ay * s_reg);
        rot_next[1] = RW'(pts.ax * s_reg) + RW'(pts.ay * c_reg);
        rot_next[2] = RW'(pts.bx * c_reg) - RW'(pts.by * s_reg);
        rot_next[3] = RW'(pts.bx * s_reg) + RW'(pts.by * c_reg);
        for (int i = 0; i < 4; i++)
        begin
            rounded[i] = (b_prod_reg[i] + PW'(1 <<< (PLACE_SH - 1))) >>> PLACE_SH;
            placed[i]  = (PW+1)'(rounded[i])
                       + (PW+1)'((i % 2 == 0) ? b_ox_reg : b_oy_reg);
            if (placed[i] > (PW+1)'(32767))
                pt_next[i] = 16'sh7fff;
            else if (placed[i] < -(PW+1)'(32768))
                pt_next[i] = -16'sh8000;
            else
                pt_next[i] = placed[i][15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            k_reg       <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= busy_reg;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            if (job_take)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (k_reg == LAST_K)
                    busy_reg <= 1'b0;
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            c_reg    <= job_cos;
            s_reg    <= job_sin;
            zoom_reg <= job_zoom;
            ox_reg   <= job_ox;
            oy_reg   <= job_oy;
        end
        if (en)
        begin
            a_k_reg    <= k_reg;
            a_zoom_reg <= zoom_reg;
            a_ox_reg   <= ox_reg;
            a_oy_reg   <= oy_reg;
            b_k_reg    <= a_k_reg;
            b_ox_reg   <= a_ox_reg;
            b_oy_reg   <= a_oy_reg;
            c_k_reg    <= b_k_reg;
            for (int i = 0; i < 4; i++)
            begin
                a_rot_reg[i]  <= rot_next[i];
                b_prod_reg[i] <= PW'(a_rot_reg[i] * $signed({1'b0, a_zoom_reg}));
                c_pt_reg[i]   <= pt_next[i];
            end
        end
    end

    assign seg.valid         = c_valid_reg;
    assign seg.segment_index = 4'(c_k_reg);
    assign seg.start_x       = c_pt_reg[0];
    assign seg.start_y       = c_pt_reg[1];
    assign seg.end_x         = c_pt_reg[2];
    assign seg.end_y         = c_pt_reg[3];
    assign seg.last_segment  = (c_k_reg == LAST_K);

endmodule

/* rtl/vector_shape_rotate_scale_translate.sv */
// ============================================================================
// vector_shape_rotate_scale_translate: ship outline transform engine
// Rotates, scales and places a fixed vector outline for each request.
// ============================================================================
// Each request item carries an angle (a fraction of a full turn), a Q8.8 zoom
// and a screen origin. The block answers with 14 segment items, twelve hull
// segments followed by two thrust-flame segments, the final one flagged by
// last_segment. Sine and cosine come from a chain of 24 CORDIC cells, one
// micro-rotation per cell, and a request is registered in each cell in turn
// on its way to the segment emitter. The emitter then issues one segment per
// cycle while the output is not stalled, through three stages (rotate, scale,
// round and place), and can take the next request while it issues the last
// segment of the current one. Requests may arrive back to back: the CORDIC
// chain holds up to 24 requests in flight and stalls only when its last cell
// holds a job the emitter has not yet taken. Coordinates are rounded to
// nearest and saturated to 16 bits. Reset clears the valid flags, the busy
// flag and the segment counter; no table or memory needs initialization.
module vector_shape_rotate_scale_translate
    import vsrst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vsrst_req_if.sink   req,
    vsrst_seg_if.source seg
);

    logic                 chain_en;
    logic                 job_take;
    logic                 chain_valid [CORDIC_STEPS+1];
    cordic_t              chain_data  [CORDIC_STEPS+1];
    cordic_t              head;
    logic                 quad_flip;
    logic signed [TW-1:0] cos_val;
    logic signed [TW-1:0] sin_val;

    // The whole chain moves together whenever its tail is free or being taken.
    assign chain_en  = !chain_valid[CORDIC_STEPS] || job_take;
    assign req.ready = chain_en;

    // Fold the angle into a quarter turn around zero; the second and third
    // quadrants add a half turn and negate the results at the end.
    assign quad_flip = req.angle[15] ^ req.angle[14];

    always_comb
    begin
        head.flip = quad_flip;
        head.zoom = req.zoom;
        head.ox   = req.origin_x;
        head.oy   = req.origin_y;
        head.x    = CORDIC_GAIN;
        head.y    = '0;
        head.z    = ZW'($signed({req.angle[15] ^ quad_flip, req.angle[14:0], 16'b0}));
    end

    assign chain_valid[0] = req.valid;
    assign chain_data[0]  = head;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        vsrst_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (chain_en),
            .shift     (SHW'(g)),
            .atan      (ATAN_TAB[g]),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    assign cos_val = to_trig(chain_data[CORDIC_STEPS].x, chain_data[CORDIC_STEPS].flip);
    assign sin_val = to_trig(chain_data[CORDIC_STEPS].y, chain_data[CORDIC_STEPS].flip);

    vsrst_seg_unit u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (chain_valid[CORDIC_STEPS]),
        .job_take  (job_take),
        .job_cos   (cos_val),
        .job_sin   (sin_val),
        .job_zoom  (chain_data[CORDIC_STEPS].zoom),
        .job_ox    (chain_data[CORDIC_STEPS].ox),
        .job_oy    (chain_data[CORDIC_STEPS].oy),
        .seg       (seg)
    );

endmodule

/* tb/vsrst_tb_if.sv */
`timescale 1ns / 100ps
// ============================================================================
// vsrst_tb_if: testbench item types for the request and segment channels
// Holds the request item that the stimulus queue carries and the segment
// item that the checker expects; the channels themselves are the RTL's.
// ============================================================================
package vsrst_tb_types;

    // One transform request as the stimulus queue holds it.
    typedef struct {
        logic [15:0]        angle;
        logic [15:0]        zoom;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
    } request_t;

    // One transformed segment as the checker expects it.
    typedef struct {
        logic [3:0]         segment_index;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               last_segment;
    } segment_t;

endpackage

/* tb/vector_shape_rotate_scale_translate_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// vector_shape_rotate_scale_translate_test: outline transform testbench
// Drives transform requests with random gaps, predicts the fourteen
// transformed segments of each with a behavioral CORDIC and rounding model,
// and compares every segment item leaving the block in order.
// ============================================================================
module vector_shape_rotate_scale_translate_test;
    import vsrst_pkg::*;
    import vsrst_tb_types::*;

    localparam int  MAX_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  STALL_CYCLES = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    vsrst_req_if req ();
    vsrst_seg_if seg ();

    vector_shape_rotate_scale_translate dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .seg   (seg.source)
    );

    always #5 clk = ~clk;

    // Requests waiting to be offered, and the segments predicted for the
    // requests that the block has already accepted.
    request_t pending_requests[$];
    segment_t expected_segments[$];

    int  failures = 0;
    int  cycle_count = 0;
    // While set, neither side idles; used for a back-to-back stretch.
    bit  steady_phase = 1'b0;
    // Set once by the stimulus to start the long receiver hold-off.
    bit  stall_armed = 1'b0;
    bit  stall_served = 1'b0;
    // While nonzero, the receiver refuses segments to back up the block.
    int  hold_off = 0;

    // ------------------------------------------------------------------------
    // Outline table, written out independently: hull segments then flame.
    // ------------------------------------------------------------------------
    function automatic void outline_point(input int k, output int ax, output int ay,
                                          output int bx, output int by);
        int t[14][4];
        t = '{'{-4, 3, 2, 0}, '{-4, -3, 2, 0}, '{-4, -3, -1, 4}, '{-4, 3, -1, -4},
              '{-1, 4, 2, 0}, '{-1, -4, 2, 0}, '{2, 0, 3, 1}, '{3, 1, 4, 0},
              '{2, 0, 3, -1}, '{3, -1, 4, 0}, '{-1, 4, 1, 4}, '{-1, -4, 1, -4},
              '{-6, 0, -3, 2}, '{-6, 0, -3, -2}};
        ax = t[k][0];
        ay = t[k][1];
        bx = t[k][2];
        by = t[k][3];
    endfunction

    // Arithmetic right shift is a floor for signed 64-bit values.
    function automatic longint rounded_trig(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 14)) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    // Sine and cosine of angle/65536 turn, Q1.15, by a 24-step CORDIC.
    function automatic void angle_trig(input logic [15:0] angle, output longint s,
                                       output longint c);
        longint atan_steps[24];
        logic [31:0] turn;
        logic [31:0] folded;
        bit     flip;
        longint x, y, z, dx, dy;
        atan_steps = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772,
                       166886, 83443, 41722, 20861, 10430, 5215,
                       2608, 1304, 652, 326, 163, 81};
        turn = {angle, 16'h0000};
        // Quadrants two and three are folded by a half turn and negated.
        flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
        folded = flip ? turn + 32'h8000_0000 : turn;
        z = longint'($signed(folded));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_steps[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_steps[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = rounded_trig(x);
        s = rounded_trig(y);
    endfunction

    // Scale a rotated coordinate, round ties upward, offset and saturate.
    function automatic logic signed [15:0] placed_coord(input longint rot,
                                                        input logic [15:0] zoom,
                                                        input logic signed [15:0] org);
        longint v;
        v = ((rot * longint'(zoom) + (64'sd1 <<< 22)) >>> 23) + longint'(org);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // Predict the whole segment run for one accepted request.
    task automatic predict_outline(input request_t r);
        longint s, c;
        int ax, ay, bx, by;
        segment_t e;
        angle_trig(r.angle, s, c);
        for (int k = 0; k < 14; k++)
        begin
            outline_point(k, ax, ay, bx, by);
            e.segment_index = k[3:0];
            e.start_x = placed_coord(ax * c - ay * s, r.zoom, r.origin_x);
            e.start_y = placed_coord(ax * s + ay * c, r.zoom, r.origin_y);
            e.end_x = placed_coord(bx * c - by * s, r.zoom, r.origin_x);
            e.end_y = placed_coord(bx * s + by * c, r.zoom, r.origin_y);
            e.last_segment = (k == 13);
            expected_segments.push_back(e);
        end
    endtask

    function automatic bit idle_now();
        return !steady_phase && ($urandom_range(99) < 38);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. The current item stays on the bus until it is accepted;
    // a new item or an idle cycle is chosen only after that.
    // ------------------------------------------------------------------------
    initial
    begin
        req.valid = 1'b0;
        req.angle = '0;
        req.zoom = '0;
        req.origin_x = '0;
        req.origin_y = '0;
        seg.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                predict_outline('{req.angle, req.zoom, req.origin_x, req.origin_y});
            if (!req.valid || req.ready)
            begin
                if (pending_requests.size() > 0 && !idle_now())
                begin
                    request_t r;
                    r = pending_requests.pop_front();
                    req.valid <= 1'b1;
                    req.angle <= r.angle;
                    req.zoom <= r.zoom;
                    req.origin_x <= r.origin_x;
                    req.origin_y <= r.origin_y;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off counter: one long stretch of refused segments.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_armed && !stall_served)
        begin
            hold_off <= STALL_CYCLES;
            stall_served <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // ------------------------------------------------------------------------
    // Segment monitor: check every accepted item against the oldest
    // expectation, then choose the ready level for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seg.valid && seg.ready)
            begin
                if (expected_segments.size() == 0)
                begin
                    $display("%0t: segment item with none expected: index %0d",
                             $time, seg.segment_index);
                    failures++;
                end
                else
                begin
                    segment_t e;
                    e = expected_segments.pop_front();
                    if (e.segment_index !== seg.segment_index)
                    begin
                        $display("%0t: segment_index expected %0d actual %0d",
                                 $time, e.segment_index, seg.segment_index);
                        failures++;
                    end
                    if (e.start_x !== seg.start_x)
                    begin
                        $display("%0t: start_x expected %0d actual %0d",
                                 $time, e.start_x, seg.start_x);
                        failures++;
                    end
                    if (e.start_y !== seg.start_y)
                    begin
                        $display("%0t: start_y expected %0d actual %0d",
                                 $time, e.start_y, seg.start_y);
                        failures++;
                    end
                    if (e.end_x !== seg.end_x)
                    begin
                        $display("%0t: end_x expected %0d actual %0d",
                                 $time, e.end_x, seg.end_x);
                        failures++;
                    end
                    if (e.end_y !== seg.end_y)
                    begin
                        $display("%0t: end_y expected %0d actual %0d",
                                 $time, e.end_y, seg.end_y);
                        failures++;
                    end
                    if (e.last_segment !== seg.last_segment)
                    begin
                        $display("%0t: last_segment expected %0d actual %0d",
                                 $time, e.last_segment, seg.last_segment);
                        failures++;
                    end
                end
            end
            if (hold_off > 0)
                seg.ready <= 1'b0;
            else
                seg.ready <= !idle_now();
        end
    end

    // Cycle limit: a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic request_t random_request();
        request_t r;
        r.angle = 16'($urandom());
        // Mostly modest zooms so results stay on screen; some hit saturation.
        case ($urandom_range(3))
            0: r.zoom = 16'($urandom());
            1: r.zoom = 16'($urandom_range(16'h0400));
            default: r.zoom = 16'($urandom_range(16'h2000));
        endcase
        r.origin_x = 16'($urandom());
        r.origin_y = 16'($urandom());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: directed corners first, then random requests. A long
    // receiver hold-off in the middle lets the CORDIC chain fill and stall
    // its input, and one stretch runs with no idling at all.
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Zero angle (cosine reads as just under one), each quadrant boundary.
        pending_requests.push_back('{16'h0000, 16'h0100, 16'sd0, 16'sd0});
        pending_requests.push_back('{16'h4000, 16'h0100, 16'sd100, -16'sd100});
        pending_requests.push_back('{16'h8000, 16'h0100, -16'sd5, 16'sd7});
        pending_requests.push_back('{16'hC000, 16'h0100, 16'sd0, 16'sd0});
        pending_requests.push_back('{16'hFFFF, 16'h0100, 16'sd0, 16'sd0});
        pending_requests.push_back('{16'h3FFF, 16'h0180, 16'sd1, 16'sd1});
        pending_requests.push_back('{16'h2000, 16'h0080, 16'sd0, 16'sd0});
        // Zero zoom lands everything on the origin, at the coordinate limits.
        pending_requests.push_back('{16'h1234, 16'h0000, 16'sh7FFF, -16'sh8000});
        pending_requests.push_back('{16'hABCD, 16'h0000, -16'sh8000, 16'sh7FFF});
        // Largest zoom and extreme origins force saturation both ways.
        pending_requests.push_back('{16'h0000, 16'hFFFF, 16'sd0, 16'sd0});
        pending_requests.push_back('{16'h5555, 16'hFFFF, 16'sh7FFF, 16'sh7FFF});
        pending_requests.push_back('{16'hAAAA, 16'hFFFF, -16'sh8000, -16'sh8000});
        pending_requests.push_back('{16'h0001, 16'h0001, 16'sh7FF0, -16'sh7FF0});
        pending_requests.push_back('{16'hFFFF, 16'hFFFF, 16'sh7FFF, -16'sh8000});
        pending_requests.push_back('{16'h7FFF, 16'h8000, 16'sh5555, 16'shAAAA});

        for (int i = 0; i < 40; i++)
            pending_requests.push_back(random_request());
        wait (pending_requests.size() == 0);

        // Receiver holds off while requests keep arriving.
        stall_armed = 1'b1;
        for (int i = 0; i < 40; i++)
            pending_requests.push_back(random_request());
        wait (pending_requests.size() == 0);

        steady_phase = 1'b1;
        for (int i = 0; i < 60; i++)
            pending_requests.push_back(random_request());
        wait (pending_requests.size() == 0);
        steady_phase = 1'b0;

        for (int i = 0; i < 105; i++)
            pending_requests.push_back(random_request());
        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (req.valid)
            @(posedge clk);

        wait (expected_segments.size() == 0);
        waited = 0;
        while (waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end

        if (failures == 0 && expected_segments.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
